// ----- hdl/tile_map_box_push_out_defines.svh -----
// Assertion macros shared by the tile push-out RTL.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef TILE_MAP_BOX_PUSH_OUT_DEFINES_SVH
`define TILE_MAP_BOX_PUSH_OUT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TMBPO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TMBPO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/tmbpo_pkg.sv -----
// Shared constants, types and helpers for the tile push-out block.
// No dependencies.
package tmbpo_pkg;

    localparam int MAP_COLS_MAX = 64;
    localparam int MAP_ROWS_MAX = 64;
    localparam int TILE_SIZE    = 64;
    localparam int AGENT_SIZE   = 60;
    localparam int AGENT_HALF   = 30;
    localparam int FRAC_BITS    = 8;

    localparam int POS_W      = 22;
    localparam int CFG_W      = 7;
    localparam int IDX_W      = 6;
    localparam int TILE_SHIFT = FRAC_BITS + $clog2(TILE_SIZE);
    // working width: input plus four pushes of at most one tile
    localparam int WPOS_W     = POS_W + 3;
    localparam int DIFF_W     = WPOS_W + 1;
    localparam int CORNER_W   = POS_W + 2;
    localparam int TIDX_W     = CORNER_W - TILE_SHIFT;
    localparam int BANK_AW    = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int CENTER_W   = IDX_W + TILE_SHIFT;

    localparam int AHALF = AGENT_HALF << FRAC_BITS;
    localparam int ASIZE = AGENT_SIZE << FRAC_BITS;
    localparam int THALF = (TILE_SIZE << FRAC_BITS) >> 1;
    localparam int MIND  = AHALF + THALF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_MAP_COLUMNS = 1'b0;
    localparam logic REG_MAP_ROWS    = 1'b1;

    typedef logic signed [WPOS_W-1:0] wpos_t;
    typedef logic [IDX_W-1:0]         tidx_t;

    // one pipeline beat
    typedef struct packed {
        logic             valid;
        logic             query;
        wpos_t            x;
        wpos_t            y;
        logic [3:0]       hit;
        logic [3:0][IDX_W-1:0] col;
        logic [3:0][IDX_W-1:0] row;
    } stage_t;

    typedef struct packed {
        logic               en;
        logic [1:0]         bank;
        logic [BANK_AW-1:0] addr;
        logic               data;
    } map_wr_t;

    typedef struct packed {
        logic                   en;
        logic [3:0][BANK_AW-1:0] addr;
    } map_rd_t;

    // center of a tile along one axis
    function automatic logic [CENTER_W-1:0] tile_center(input tidx_t idx);
        logic [TILE_SHIFT-1:0] half;
        half = TILE_SHIFT'(THALF);
        return {idx, half};
    endfunction

endpackage

// ----- hdl/tmbpo_map.sv -----
// Solid tile bitmap split into four banks by row and column parity.
// Depends on tmbpo_pkg.
module tmbpo_map (
    input  logic             clk,
    input  tmbpo_pkg::map_wr_t wr,
    input  tmbpo_pkg::map_rd_t rd,
    output logic [3:0]       rd_data
);

    // one write port and one registered read port per bank
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic mem [0:tmbpo_pkg::BANK_DEPTH-1];
        logic rd_bit_reg;

        always_ff @(posedge clk)
        begin
            if (wr.en && (wr.bank == 2'(b)))
            begin
                mem[wr.addr] <= wr.data;
            end
            if (rd.en)
            begin
                rd_bit_reg <= mem[rd.addr[b]];
            end
        end

        assign rd_data[b] = rd_bit_reg;
    end

endmodule

// ----- hdl/tmbpo_push.sv -----
// One push-out step: moves the position out of the tile under one corner.
// Depends on tmbpo_pkg.
module tmbpo_push (
    input  tmbpo_pkg::stage_t in,
    input  logic [1:0]        corner,
    output tmbpo_pkg::stage_t out
);

    localparam int DW = tmbpo_pkg::DIFF_W;

    logic signed [DW-1:0] cx, cy, dx, dy, adx, ady, xd, yd, xp, yp;
    logic signed [DW-1:0] nx, ny;
    logic                 act;

    always_comb
    begin
        // distance from agent center to tile center
        cx  = signed'(DW'(tmbpo_pkg::tile_center(in.col[corner])));
        cy  = signed'(DW'(tmbpo_pkg::tile_center(in.row[corner])));
        dx  = DW'(in.x) + DW'(tmbpo_pkg::AHALF) - cx;
        dy  = DW'(in.y) + DW'(tmbpo_pkg::AHALF) - cy;
        adx = dx[DW-1] ? -dx : dx;
        ady = dy[DW-1] ? -dy : dy;
        // overlap depth per axis
        xd  = DW'(tmbpo_pkg::MIND) - adx;
        yd  = DW'(tmbpo_pkg::MIND) - ady;
        xp  = (xd > 0) ? xd : '0;
        yp  = (yd > 0) ? yd : '0;
        act = in.hit[corner] && ((xd > 0) || (yd > 0));

        nx = DW'(in.x);
        ny = DW'(in.y);
        if (act)
        begin
            if (xp < yp)
            begin
                nx = dx[DW-1] ? (nx - xd) : (nx + xd);
            end
            else
            begin
                ny = dy[DW-1] ? (ny - yd) : (ny + yd);
            end
        end

        out   = in;
        out.x = nx[tmbpo_pkg::WPOS_W-1:0];
        out.y = ny[tmbpo_pkg::WPOS_W-1:0];
    end

endmodule

// ----- hdl/tile_map_box_push_out.sv -----
// Top level of the tile push-out block: map lookup and four push stages.
// Depends on tmbpo_pkg, tmbpo_map, tmbpo_push and the defines header.
//
//  channel  | handshake           | fields
//  ---------+---------------------+---------------------------------------------
//  input    | start / busy        | op, tile_column, tile_row, tile_solid, pos_x, pos_y
//  result   | done (strobe)       | new_x, new_y, collided
//  config   | cfg_wr_en           | cfg_index, cfg_data
//
// One beat enters every cycle; busy is always low. The edge that takes a beat
// also reads the banked map; the four push stages then each apply one corner
// push in turn, and the result reaches the ports from the last stage register.
// The four map banks (row/column parity) give each corner its own read port.
// Reset clears the stage valid bits and sets the map size config to its maxima;
// the map holds no reset contents. The receiver cannot stall, so nothing waits.
`include "tile_map_box_push_out_defines.svh"

module tile_map_box_push_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              op,
    input  logic [tmbpo_pkg::IDX_W-1:0]       tile_column,
    input  logic [tmbpo_pkg::IDX_W-1:0]       tile_row,
    input  logic                              tile_solid,
    input  logic signed [tmbpo_pkg::POS_W-1:0] pos_x,
    input  logic signed [tmbpo_pkg::POS_W-1:0] pos_y,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [tmbpo_pkg::CFG_W-1:0]       cfg_data,
    output logic                              done,
    output logic signed [tmbpo_pkg::POS_W-1:0] new_x,
    output logic signed [tmbpo_pkg::POS_W-1:0] new_y,
    output logic                              collided
);

    localparam int CW = tmbpo_pkg::CORNER_W;
    localparam int TW = tmbpo_pkg::TIDX_W;
    localparam int PW = tmbpo_pkg::POS_W;
    localparam int WW = tmbpo_pkg::WPOS_W;
    localparam int IW = tmbpo_pkg::IDX_W;
    localparam tmbpo_pkg::wpos_t POS_MAX = WW'((2 ** (PW - 1)) - 1);
    localparam tmbpo_pkg::wpos_t POS_MIN = -POS_MAX - WW'(1);

    logic [tmbpo_pkg::CFG_W-1:0] map_columns_reg, map_rows_reg;
    logic [tmbpo_pkg::CFG_W-1:0] cols_lim, rows_lim;
    logic                        accept;

    logic signed [CW-1:0] cx0, cx1, cy0, cy1;
    logic signed [TW-1:0] tc0, tc1, tr0, tr1;
    logic [1:0]           col_in, row_in;
    logic [3:0]           corner_ok;
    logic [1:0][IW-1:0]   cols, rows;

    tmbpo_pkg::map_wr_t map_wr;
    tmbpo_pkg::map_rd_t map_rd;
    logic [3:0]         map_data;

    tmbpo_pkg::stage_t s0_next;
    tmbpo_pkg::stage_t s_reg [1:5];
    tmbpo_pkg::stage_t p_in  [1:4];
    tmbpo_pkg::stage_t p_out [1:4];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_columns_reg <= tmbpo_pkg::CFG_W'(tmbpo_pkg::MAP_COLS_MAX);
            map_rows_reg    <= tmbpo_pkg::CFG_W'(tmbpo_pkg::MAP_ROWS_MAX);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tmbpo_pkg::REG_MAP_COLUMNS: map_columns_reg <= cfg_data;
                tmbpo_pkg::REG_MAP_ROWS:    map_rows_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cols_lim = (map_columns_reg > tmbpo_pkg::CFG_W'(tmbpo_pkg::MAP_COLS_MAX))
                    ? tmbpo_pkg::CFG_W'(tmbpo_pkg::MAP_COLS_MAX) : map_columns_reg;
    assign rows_lim = (map_rows_reg > tmbpo_pkg::CFG_W'(tmbpo_pkg::MAP_ROWS_MAX))
                    ? tmbpo_pkg::CFG_W'(tmbpo_pkg::MAP_ROWS_MAX) : map_rows_reg;

    // corner tiles: floor division by the tile size is an arithmetic shift
    always_comb
    begin
        cx0 = CW'(pos_x);
        cy0 = CW'(pos_y);
        cx1 = cx0 + CW'(tmbpo_pkg::ASIZE);
        cy1 = cy0 + CW'(tmbpo_pkg::ASIZE);
        tc0 = cx0[CW-1:tmbpo_pkg::TILE_SHIFT];
        tc1 = cx1[CW-1:tmbpo_pkg::TILE_SHIFT];
        tr0 = cy0[CW-1:tmbpo_pkg::TILE_SHIFT];
        tr1 = cy1[CW-1:tmbpo_pkg::TILE_SHIFT];
        col_in[0] = !tc0[TW-1] && (tc0[TW-2:0] < (TW-1)'(cols_lim));
        col_in[1] = !tc1[TW-1] && (tc1[TW-2:0] < (TW-1)'(cols_lim));
        row_in[0] = !tr0[TW-1] && (tr0[TW-2:0] < (TW-1)'(rows_lim));
        row_in[1] = !tr1[TW-1] && (tr1[TW-2:0] < (TW-1)'(rows_lim));
        cols[0] = tc0[IW-1:0];
        cols[1] = tc1[IW-1:0];
        rows[0] = tr0[IW-1:0];
        rows[1] = tr1[IW-1:0];
        for (int k = 0; k < 4; k++)
        begin
            corner_ok[k] = col_in[k % 2] && row_in[k / 2];
        end
    end

    // map access: each bank serves the corner whose parity matches it
    always_comb
    begin
        logic [IW-1:0] bc, br;
        map_wr.en   = accept && (op == tmbpo_pkg::OP_WRITE);
        map_wr.bank = {tile_row[0], tile_column[0]};
        map_wr.addr = {tile_row[IW-1:1], tile_column[IW-1:1]};
        map_wr.data = tile_solid;
        map_rd.en   = accept && (op == tmbpo_pkg::OP_QUERY);
        for (int b = 0; b < 4; b++)
        begin
            bc = (cols[0][0] == b[0]) ? cols[0] : cols[1];
            br = (rows[0][0] == b[1]) ? rows[0] : rows[1];
            map_rd.addr[b] = {br[IW-1:1], bc[IW-1:1]};
        end
    end

    tmbpo_map u_map (
        .clk     (clk),
        .wr      (map_wr),
        .rd      (map_rd),
        .rd_data (map_data)
    );

    // entry beat; idle slots carry no corner hits
    always_comb
    begin
        s0_next.valid = accept;
        s0_next.query = (op == tmbpo_pkg::OP_QUERY);
        s0_next.x     = WW'(pos_x);
        s0_next.y     = WW'(pos_y);
        s0_next.hit   = (accept && (op == tmbpo_pkg::OP_QUERY)) ? corner_ok : 4'b0000;
        for (int k = 0; k < 4; k++)
        begin
            s0_next.col[k] = cols[k % 2];
            s0_next.row[k] = rows[k / 2];
        end
    end

    // first push stage sees the map data merged into the hit mask
    always_comb
    begin
        p_in[1] = s_reg[1];
        for (int k = 0; k < 4; k++)
        begin
            p_in[1].hit[k] = s_reg[1].hit[k]
                           && map_data[{s_reg[1].row[k][0], s_reg[1].col[k][0]}];
        end
    end

    for (genvar i = 2; i <= 4; i++) begin : g_pin
        assign p_in[i] = s_reg[i];
    end

    for (genvar i = 1; i <= 4; i++) begin : g_push
        tmbpo_push u_push (
            .in     (p_in[i]),
            .corner (2'(i - 1)),
            .out    (p_out[i])
        );
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 5; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            s_reg[1] <= s0_next;
            for (int i = 1; i <= 4; i++)
            begin
                s_reg[i+1] <= p_out[i];
            end
        end
    end

    // result with saturation to the port range
    assign done     = s_reg[5].valid;
    assign collided = s_reg[5].query && (s_reg[5].hit != 4'b0000);
    assign new_x = (s_reg[5].x > POS_MAX) ? PW'(POS_MAX) :
                   (s_reg[5].x < POS_MIN) ? PW'(POS_MIN) : s_reg[5].x[PW-1:0];
    assign new_y = (s_reg[5].y > POS_MAX) ? PW'(POS_MAX) :
                   (s_reg[5].y < POS_MIN) ? PW'(POS_MIN) : s_reg[5].y[PW-1:0];

    `TMBPO_ASSERT(a_latency, (start && !busy) |-> ##5 done, "accepted beat did not complete")
    `TMBPO_ASSERT(a_write_no_hit, (s_reg[1].valid && !s_reg[1].query) |-> (s_reg[1].hit == 4'b0000),
        "map write carries corner hits")
    `TMBPO_ASSERT(a_write_echo, (done && !s_reg[5].query) |-> (new_x == $past(pos_x, 5)),
        "map write result does not echo x")
    `TMBPO_ASSERT_ALWAYS(a_collided_strobe, collided |-> done, "collided without strobe")

endmodule

// ----- test/tmbpo_checker.sv -----
// Result checker for tile_map_box_push_out: watches the input, result and config ports.
// Keeps its own tile bitmap and map size, and predicts each result.
// Depends on tmbpo_pkg.
`timescale 1ns / 1ps

module tmbpo_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              op,
    input  logic [tmbpo_pkg::IDX_W-1:0]       tile_column,
    input  logic [tmbpo_pkg::IDX_W-1:0]       tile_row,
    input  logic                              tile_solid,
    input  logic signed [tmbpo_pkg::POS_W-1:0] pos_x,
    input  logic signed [tmbpo_pkg::POS_W-1:0] pos_y,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [tmbpo_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              done,
    input  logic signed [tmbpo_pkg::POS_W-1:0] new_x,
    input  logic signed [tmbpo_pkg::POS_W-1:0] new_y,
    input  logic                              collided,
    output int                                fails,
    output int                                pending
);

    localparam int PW = tmbpo_pkg::POS_W;
    localparam int IW = tmbpo_pkg::IDX_W;
    localparam int NCOLS = tmbpo_pkg::MAP_COLS_MAX;
    localparam int NROWS = tmbpo_pkg::MAP_ROWS_MAX;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic                 hit;
    } placement_t;

    localparam longint TILE_FX = longint'(tmbpo_pkg::TILE_SIZE) << tmbpo_pkg::FRAC_BITS;
    localparam int TSHIFT = tmbpo_pkg::FRAC_BITS + $clog2(tmbpo_pkg::TILE_SIZE);

    logic        solid_tiles [NROWS * NCOLS];
    logic [tmbpo_pkg::CFG_W-1:0] cols_in_use;
    logic [tmbpo_pkg::CFG_W-1:0] rows_in_use;
    placement_t  placements [$];

    function automatic logic signed [PW-1:0] clamp_pos(input longint v);
        longint hi;
        hi = (longint'(1) << (PW - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[PW-1:0];
    endfunction

    // Bitmap write or push-out of one agent box.
    function automatic placement_t place_agent(input logic opv, input logic [IW-1:0] c,
                                               input logic [IW-1:0] r, input logic s,
                                               input longint x0, input longint y0);
        placement_t res;
        longint px, py, cx, cy, tc, tr, dx, dy, xd, yd, xp, yp, lim_c, lim_r;
        longint hx [4];
        longint hy [4];
        int nhit;
        px = x0;
        py = y0;
        nhit = 0;
        if (opv == tmbpo_pkg::OP_WRITE)
        begin
            solid_tiles[int'(r) * NCOLS + int'(c)] = s;
            res.x = clamp_pos(px);
            res.y = clamp_pos(py);
            res.hit = 1'b0;
            return res;
        end
        lim_c = (cols_in_use > NCOLS) ? NCOLS : cols_in_use;
        lim_r = (rows_in_use > NROWS) ? NROWS : rows_in_use;
        // corner lookups on the original position
        for (int k = 0; k < 4; k++)
        begin
            cx = px + ((k & 1) ? tmbpo_pkg::ASIZE : 0);
            cy = py + ((k & 2) ? tmbpo_pkg::ASIZE : 0);
            tc = cx >>> TSHIFT;
            tr = cy >>> TSHIFT;
            if (tc < 0 || tc >= lim_c || tr < 0 || tr >= lim_r) continue;
            if (solid_tiles[tr * NCOLS + tc])
            begin
                hx[nhit] = tc * TILE_FX + tmbpo_pkg::THALF;
                hy[nhit] = tr * TILE_FX + tmbpo_pkg::THALF;
                nhit++;
            end
        end
        // pushes in corner order on the running position
        for (int k = 0; k < nhit; k++)
        begin
            dx = px + tmbpo_pkg::AHALF - hx[k];
            dy = py + tmbpo_pkg::AHALF - hy[k];
            xd = tmbpo_pkg::MIND - (dx < 0 ? -dx : dx);
            yd = tmbpo_pkg::MIND - (dy < 0 ? -dy : dy);
            if (xd > 0 || yd > 0)
            begin
                xp = xd > 0 ? xd : 0;
                yp = yd > 0 ? yd : 0;
                if (xp < yp) px = (dx < 0) ? px - xd : px + xd;
                else         py = (dy < 0) ? py - yd : py + yd;
            end
        end
        res.x = clamp_pos(px);
        res.y = clamp_pos(py);
        res.hit = (nhit > 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            cols_in_use <= tmbpo_pkg::CFG_W'(NCOLS);
            rows_in_use <= tmbpo_pkg::CFG_W'(NROWS);
            placements.delete();
            fails <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == tmbpo_pkg::REG_MAP_COLUMNS) cols_in_use <= cfg_data;
                else                                         rows_in_use <= cfg_data;
            end
            if (start && !busy)
                placements.insert(placements.size(),
                                  place_agent(op, tile_column, tile_row, tile_solid,
                                              longint'(pos_x), longint'(pos_y)));
            if (done)
            begin
                if (placements.size() == 0)
                begin
                    if (fails < 10)
                        $display("ERROR: result beat with none expected: x=%0d y=%0d c=%0b",
                                 new_x, new_y, collided);
                    fails <= fails + 1;
                end
                else
                begin
                    want = placements.pop_front();
                    if (want.x !== new_x || want.y !== new_y || want.hit !== collided)
                    begin
                        if (fails < 10)
                            $display("ERROR: exp x=%0d y=%0d c=%0b, got x=%0d y=%0d c=%0b",
                                     want.x, want.y, want.hit, new_x, new_y, collided);
                        fails <= fails + 1;
                    end
                end
            end
            pending <= placements.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for tile_map_box_push_out: clock, reset, stimulus and verdict.
// Depends on tmbpo_pkg, the block and tmbpo_checker.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TILE_FX = tmbpo_pkg::TILE_SIZE << tmbpo_pkg::FRAC_BITS;
    localparam int ASIZE = tmbpo_pkg::ASIZE;
    localparam int IW = tmbpo_pkg::IDX_W;
    localparam int PW = tmbpo_pkg::POS_W;
    localparam int CFGW = tmbpo_pkg::CFG_W;
    // fully loaded block of tiles; row 0 and column 0 are loaded across the map
    localparam int LOAD_SPAN = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic op = tmbpo_pkg::OP_WRITE;
    logic [IW-1:0] tile_column = '0;
    logic [IW-1:0] tile_row = '0;
    logic tile_solid = 1'b0;
    logic signed [PW-1:0] pos_x = '0;
    logic signed [PW-1:0] pos_y = '0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = tmbpo_pkg::REG_MAP_COLUMNS;
    logic [CFGW-1:0] cfg_data = '0;
    logic done;
    logic signed [PW-1:0] new_x;
    logic signed [PW-1:0] new_y;
    logic collided;
    int fails;
    int pending;
    int idle_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tile_map_box_push_out dut (.*);

    tmbpo_checker u_checker (.*);

    // watchdog: cycles with no beat in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // random idle cycles, then one beat
    task automatic send_beat(input logic o, input int c, input int r, input logic s,
                             input int x, input int y);
        logic b;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        tile_column <= IW'(c);
        tile_row <= IW'(r);
        tile_solid <= s;
        pos_x <= PW'(x);
        pos_y <= PW'(y);
        do
        begin
            @(negedge clk) b = busy;
            @(posedge clk);
        end while (b);
    endtask

    task automatic query(input int x, input int y);
        send_beat(tmbpo_pkg::OP_QUERY, $urandom, $urandom, 1'($urandom), x, y);
    endtask

    // drain the pipe, then write both map size registers
    task automatic set_map_size(input logic [CFGW-1:0] cols, input logic [CFGW-1:0] rows);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= tmbpo_pkg::REG_MAP_COLUMNS;
        cfg_data <= cols;
        @(posedge clk);
        cfg_index <= tmbpo_pkg::REG_MAP_ROWS;
        cfg_data <= rows;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // position near the first span tiles, often snapped to a tile edge
    function automatic int near_map(input int span);
        int v;
        if ($urandom_range(3) == 0)
            v = $urandom_range(0, span) * TILE_FX - ASIZE + $urandom_range(0, 2 * ASIZE);
        else
            v = $urandom_range(0, span * TILE_FX + 40000) - 20000;
        return v;
    endfunction

    initial
    begin
        logic [CFGW-1:0] cols_set [6];
        logic [CFGW-1:0] rows_set [6];
        int span_c;
        int span_r;
        cols_set = '{7'd16, 7'd1, 7'd127, 7'd1, 7'd13, 7'd16};
        rows_set = '{7'd16, 7'd1, 7'd1, 7'd127, 7'd9, 7'd16};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every tile a query can reach under the map sizes used below
        for (int r = 0; r < tmbpo_pkg::MAP_ROWS_MAX; r++)
            for (int c = 0; c < tmbpo_pkg::MAP_COLS_MAX; c++)
                if ((r < LOAD_SPAN && c < LOAD_SPAN) || r == 0 || c == 0)
                    send_beat(tmbpo_pkg::OP_WRITE, c, r, $urandom_range(99) < 30,
                              $urandom, $urandom);

        // directed: tile corners, field extremes, pushes on each side
        set_map_size(CFGW'(LOAD_SPAN), CFGW'(LOAD_SPAN));
        send_beat(tmbpo_pkg::OP_WRITE, 0, 0, 1'b1, 2097151, -2097152);
        send_beat(tmbpo_pkg::OP_WRITE, LOAD_SPAN - 1, LOAD_SPAN - 1, 1'b1, -2097152, 2097151);
        send_beat(tmbpo_pkg::OP_WRITE, 1, 0, 1'b0, 0, 0);
        query(0, 0);
        query(-2097152, -2097152);
        query(2097151, 2097151);
        query(-2097152, 2097151);
        query(-ASIZE + 1, -ASIZE + 1);
        query(-ASIZE, 0);
        query(TILE_FX - ASIZE, 0);
        query(TILE_FX - ASIZE + 1, 0);
        query(TILE_FX / 2, TILE_FX / 4);
        query(15 * TILE_FX, 15 * TILE_FX);
        query(16 * TILE_FX - 1, 15 * TILE_FX + 100);
        query(16 * TILE_FX, 16 * TILE_FX);
        query(15 * TILE_FX + 10000, 15 * TILE_FX - 30);
        query(-1, -1);
        query(50, 15 * TILE_FX + 5000);

        // random phases over several map sizes and idle rates
        for (int ph = 0; ph < 6; ph++)
        begin
            set_map_size(cols_set[ph], rows_set[ph]);
            span_c = (cols_set[ph] > tmbpo_pkg::MAP_COLS_MAX)
                   ? tmbpo_pkg::MAP_COLS_MAX : int'(cols_set[ph]);
            span_r = (rows_set[ph] > tmbpo_pkg::MAP_ROWS_MAX)
                   ? tmbpo_pkg::MAP_ROWS_MAX : int'(rows_set[ph]);
            idle_pct = (ph < 2) ? 10 : (ph < 4) ? 75 : 0;
            for (int n = 0; n < 245; n++)
            begin
                case ($urandom_range(9))
                    0, 1: send_beat(tmbpo_pkg::OP_WRITE, $urandom, $urandom,
                                    $urandom_range(99) < 35, $urandom, $urandom);
                    2: query($urandom, $urandom);
                    default: query(near_map(span_c), near_map(span_r));
                endcase
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tmbpo_pkg.sv
hdl/tmbpo_map.sv
hdl/tmbpo_push.sv
hdl/tile_map_box_push_out.sv
test/tmbpo_checker.sv
test/tb.sv
